### rtl/paged_frame_allocator_top_macros.svh
// ----------------------------------------------------------------------------
// Paged frame allocator assertion macros
// Shared concurrent assertion forms, clocked on i_clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PAGED_FRAME_ALLOCATOR_TOP_MACROS_SVH
`define PAGED_FRAME_ALLOCATOR_TOP_MACROS_SVH

// condition holds on every clock edge
`define PFA_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("pfa: invariant violated");

// same-cycle implication
`define PFA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pfa: implication violated");

// next-cycle implication
`define PFA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pfa: sequence violated");

`endif

### rtl/pfa_pkg.sv
// ----------------------------------------------------------------------------
// Paged frame allocator package
// Transaction types, field widths, status codes and sequencer states.
// ----------------------------------------------------------------------------
package pfa_pkg;

    localparam int PID_W    = 5;
    localparam int SIZE_W   = 16;
    localparam int STATUS_W = 2;
    localparam int PAGE_W   = 5;
    localparam int FRAME_W  = 5;
    localparam int USED_W   = 6;
    localparam int SHIFT_W  = 4;

    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd10;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_MAPPED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FREED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOROOM = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ACTIVE = 2'd3;

    typedef struct packed {
        logic              opcode;
        logic [PID_W-1:0]  process_id;
        logic [SIZE_W-1:0] request_size;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PAGE_W-1:0]   page_number;
        logic [FRAME_W-1:0]  frame_number;
        logic [USED_W-1:0]   frames_used;
        logic                last;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_ALLOC,
        S_FREE,
        S_FREE_TAIL,
        S_REPORT
    } t_state;

endpackage

### rtl/paged_frame_allocator_top.sv
// ----------------------------------------------------------------------------
// Paged frame allocator
// First-fit page frame allocator: busy bitmap, per-frame owner RAM,
// per-process active bits.
//
//   channel  direction  handshake                     payload
//   in       input      i_in_valid / o_in_ready       i_in_data  (t_in_item)
//   out      output     o_out_valid / i_out_ready     o_out_data (t_out_item)
//   cfg      input      i_cfg_we                      i_cfg_data (page_shift)
//
// Allocate: first-fit scan from frame 0, stopping at the last frame used.
// Free: sweeps every frame, one owner RAM read per frame through the sweep.
// Rejects go straight to the report. One transaction in flight at a time.
// Synchronous reset clears the bitmap, active bits and counters at once.
// A stalled output holds the sequencer only when a result must be loaded.
// ----------------------------------------------------------------------------
module paged_frame_allocator_top
    import pfa_pkg::*;
#(
    parameter int FRAMES    = 32,
    parameter int PROCESSES = 26
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out_data,
    input  logic               i_cfg_we,
    input  logic [SHIFT_W-1:0] i_cfg_data
);

`include "paged_frame_allocator_top_macros.svh"

    localparam int IW  = $clog2(FRAMES);
    localparam int UW  = $clog2(FRAMES + 1);
    localparam int PIW = $clog2(PROCESSES);
    localparam logic [IW-1:0] LAST_IDX = IW'(FRAMES - 1);

    t_state               r_state, n_state;
    t_in_item             r_req, n_req;
    logic [IW-1:0]        r_idx, n_idx;
    logic [IW-1:0]        r_page, n_page;
    logic [IW-1:0]        r_pages_m1, n_pages_m1;
    logic [STATUS_W-1:0]  r_status, n_status;
    logic [FRAMES-1:0]    r_busy, n_busy;
    logic [PROCESSES-1:0] r_active, n_active;
    logic [UW-1:0]        r_used, n_used;
    logic                 r_rd_vld, n_rd_vld;
    logic [IW-1:0]        r_rd_idx, n_rd_idx;
    logic                 r_out_vld, n_out_vld;
    t_out_item            r_out, n_out;
    logic [SHIFT_W-1:0]   r_page_shift;

    logic                 ram_we;
    logic [PID_W-1:0]     ram_rdata;
    logic                 out_free;
    logic                 pid_ok;
    logic [PIW-1:0]       pid_idx;
    logic [SIZE_W-1:0]    size_sh;
    logic [SIZE_W+1:0]    need;

    pfa_ram #(
        .WIDTH (PID_W),
        .DEPTH (FRAMES)
    ) u_owner_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata (r_req.process_id),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    assign out_free = !r_out_vld || i_out_ready;
    assign pid_ok   = ((SIZE_W+2)'(r_req.process_id) < (SIZE_W+2)'(PROCESSES));
    assign pid_idx  = r_req.process_id[PIW-1:0];
    assign size_sh  = r_req.request_size >> r_page_shift;
    assign need     = (SIZE_W+2)'(r_used) + (SIZE_W+2)'(size_sh) + (SIZE_W+2)'(1);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    always_comb begin
        n_state    = r_state;
        n_req      = r_req;
        n_idx      = r_idx;
        n_page     = r_page;
        n_pages_m1 = r_pages_m1;
        n_status   = r_status;
        n_busy     = r_busy;
        n_active   = r_active;
        n_used     = r_used;
        n_rd_vld   = 1'b0;
        n_rd_idx   = r_idx;
        n_out_vld  = r_out_vld && !i_out_ready;
        n_out      = r_out;
        ram_we     = 1'b0;

        // owner compare for the free sweep, one frame per cycle
        if (r_rd_vld && r_busy[r_rd_idx] && (ram_rdata == r_req.process_id)) begin
            n_busy[r_rd_idx] = 1'b0;
            n_used           = r_used - UW'(1);
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req   = i_in_data;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_idx  = '0;
                n_page = '0;
                if (r_req.opcode == OP_FREE) begin
                    if (pid_ok) begin
                        n_state = S_FREE;
                    end else begin
                        n_status = ST_FREED;
                        n_state  = S_REPORT;
                    end
                end else if (!pid_ok) begin
                    n_status = ST_NOROOM;
                    n_state  = S_REPORT;
                end else if (r_active[pid_idx]) begin
                    n_status = ST_ACTIVE;
                    n_state  = S_REPORT;
                end else if (need > (SIZE_W+2)'(FRAMES)) begin
                    n_status = ST_NOROOM;
                    n_state  = S_REPORT;
                end else begin
                    n_pages_m1 = IW'(size_sh);
                    n_state    = S_ALLOC;
                end
            end
            S_ALLOC: begin
                if (r_busy[r_idx]) begin
                    n_idx = r_idx + IW'(1);
                end else if (out_free) begin
                    ram_we                   = 1'b1;
                    n_busy[r_idx]            = 1'b1;
                    n_used                   = r_used + UW'(1);
                    n_out_vld                = 1'b1;
                    n_out.status             = ST_MAPPED;
                    n_out.page_number        = PAGE_W'(r_page);
                    n_out.frame_number       = FRAME_W'(r_idx);
                    n_out.frames_used        = USED_W'(r_used + UW'(1));
                    n_out.last               = (r_page == r_pages_m1);
                    n_idx                    = r_idx + IW'(1);
                    n_page                   = r_page + IW'(1);
                    if (r_page == r_pages_m1) begin
                        n_active[pid_idx] = 1'b1;
                        n_state           = S_IDLE;
                    end
                end
            end
            S_FREE: begin
                n_rd_vld = 1'b1;
                n_rd_idx = r_idx;
                if (r_idx == LAST_IDX) begin
                    n_state = S_FREE_TAIL;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            S_FREE_TAIL: begin
                n_active[pid_idx] = 1'b0;
                n_status          = ST_FREED;
                n_state           = S_REPORT;
            end
            S_REPORT: begin
                if (out_free) begin
                    n_out_vld          = 1'b1;
                    n_out.status       = r_status;
                    n_out.page_number  = '0;
                    n_out.frame_number = '0;
                    n_out.frames_used  = USED_W'(r_used);
                    n_out.last         = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_busy       <= '0;
            r_active     <= '0;
            r_used       <= '0;
            r_rd_vld     <= 1'b0;
            r_out_vld    <= 1'b0;
            r_page_shift <= SHIFT_RESET;
        end else begin
            r_state   <= n_state;
            r_busy    <= n_busy;
            r_active  <= n_active;
            r_used    <= n_used;
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
            if (i_cfg_we) begin
                r_page_shift <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_idx      <= n_idx;
        r_page     <= n_page;
        r_pages_m1 <= n_pages_m1;
        r_status   <= n_status;
        r_rd_idx   <= n_rd_idx;
        r_out      <= n_out;
    end

    `PFA_ASSERT_ALWAYS(a_used_matches_bitmap, $countones(r_busy) == int'(r_used))
    `PFA_ASSERT_ALWAYS(a_used_in_range, r_used <= UW'(FRAMES))
    `PFA_ASSERT_IMP(a_alloc_has_room, r_state == S_ALLOC, r_used < UW'(FRAMES))
    `PFA_ASSERT_NXT(a_accept_to_check, i_in_valid && o_in_ready, r_state == S_CHECK)

endmodule

### rtl/pfa_ram.sv
// ----------------------------------------------------------------------------
// Paged frame allocator RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pfa_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### test/tb_paged_frame_allocator_top.sv
// ----------------------------------------------------------------------------
// Paged frame allocator testbench
// Drives allocate and free transactions through the input channel while an
// internal bitmap predictor works out every page-to-frame grant and status
// result; the monitor compares each output transaction field by field.
// page_shift is reprogrammed between phases (0 and 15 included), both sides
// idle in random bursts, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_paged_frame_allocator_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pfa_pkg::*;

    localparam int FRAMES       = 32;
    localparam int PROCS        = 26;
    localparam int WATCH_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 48;
    localparam int LONG_HOLD    = 400;
    localparam int PHASE_ITEMS  = 38;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    t_in_item           i_in_data   = '0;
    logic               i_out_ready = 1'b0;
    logic               i_cfg_we    = 1'b0;
    logic [SHIFT_W-1:0] i_cfg_data  = '0;
    logic               o_in_ready;
    logic               o_out_valid;
    t_out_item          o_out_data;

    t_in_item  request_q[$];
    t_out_item grant_q[$];

    // predictor state
    bit                 m_busy[FRAMES];
    logic [PID_W-1:0]   m_owner[FRAMES];
    bit                 m_active[PROCS];
    logic [SHIFT_W-1:0] m_shift = SHIFT_RESET;

    logic [SHIFT_W-1:0] gen_shift = SHIFT_RESET;
    bit idle_en       = 1'b1;
    bit long_hold_req = 1'b0;
    bit in_taken      = 1'b0;
    int in_gap        = 0;
    int out_hold      = 0;
    int quiet         = 0;
    int fail_cnt      = 0;
    int n_sent        = 0;
    int n_req         = 0;
    int n_map         = 0;
    int n_freed       = 0;
    int n_noroom      = 0;
    int n_busy_rej    = 0;

    paged_frame_allocator_top #(
        .FRAMES    (FRAMES),
        .PROCESSES (PROCS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    task automatic predict_frame_grants(input t_in_item req);
        int used;
        int pages;
        int f;
        int p;
        int pid;
        t_out_item res;
        used = 0;
        for (f = 0; f < FRAMES; f++) begin
            if (m_busy[f]) used++;
        end
        pid = int'(req.process_id);
        res = '0;
        res.last = 1'b1;
        if (req.opcode == OP_FREE) begin
            if (pid < PROCS) begin
                for (f = 0; f < FRAMES; f++) begin
                    if (m_busy[f] && m_owner[f] == req.process_id) begin
                        m_busy[f] = 1'b0;
                        used--;
                    end
                end
                m_active[pid] = 1'b0;
            end
            res.status      = ST_FREED;
            res.frames_used = USED_W'(used);
            grant_q.insert(grant_q.size(), res);
        end else if (pid >= PROCS) begin
            res.status      = ST_NOROOM;
            res.frames_used = USED_W'(used);
            grant_q.insert(grant_q.size(), res);
        end else if (m_active[pid]) begin
            res.status      = ST_ACTIVE;
            res.frames_used = USED_W'(used);
            grant_q.insert(grant_q.size(), res);
        end else begin
            pages = (int'(req.request_size) >> m_shift) + 1;
            if (used + pages > FRAMES) begin
                res.status      = ST_NOROOM;
                res.frames_used = USED_W'(used);
                grant_q.insert(grant_q.size(), res);
            end else begin
                f = 0;
                for (p = 0; p < pages; p++) begin
                    while (f < FRAMES && m_busy[f]) f++;
                    m_busy[f]  = 1'b1;
                    m_owner[f] = req.process_id;
                    used++;
                    res.status       = ST_MAPPED;
                    res.page_number  = PAGE_W'(p);
                    res.frame_number = FRAME_W'(f);
                    res.frames_used  = USED_W'(used);
                    res.last         = (p == pages - 1);
                    grant_q.insert(grant_q.size(), res);
                end
                m_active[pid] = 1'b1;
            end
        end
    endtask

    task automatic report_field(input string name, input int want, input int got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        fail_cnt++;
    endtask

    // input driver
    always @(negedge i_clk) begin
        logic     nv;
        t_in_item nd;
        nv = i_in_valid;
        nd = i_in_data;
        if (in_taken) begin
            nv = 1'b0;
            in_taken = 1'b0;
            if (idle_en && $urandom_range(0, 3) == 0) in_gap = $urandom_range(1, 9);
        end
        if (i_rst_n && !nv) begin
            if (in_gap > 0) begin
                in_gap--;
            end else if (request_q.size() > 0) begin
                nd = request_q.pop_front();
                nv = 1'b1;
            end
        end
        i_in_valid <= nv;
        i_in_data  <= nd;
    end

    // output ready, with random stalls and one long hold-off
    always @(negedge i_clk) begin
        logic rdy;
        if (long_hold_req) begin
            long_hold_req = 1'b0;
            out_hold = LONG_HOLD;
        end
        if (out_hold > 0) begin
            out_hold--;
            rdy = 1'b0;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
            out_hold = $urandom_range(0, 8);
            rdy = 1'b0;
        end else begin
            rdy = 1'b1;
        end
        i_out_ready <= rdy;
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (i_cfg_we) m_shift = i_cfg_data;
            if (i_in_valid && o_in_ready) begin
                predict_frame_grants(i_in_data);
                in_taken = 1'b1;
                n_req++;
            end
            if (o_out_valid && i_out_ready) begin
                if (grant_q.size() == 0) begin
                    $display("%0t: unexpected result, actual %p", $time, o_out_data);
                    fail_cnt++;
                end else begin
                    want = grant_q.pop_front();
                    if (o_out_data.status !== want.status)
                        report_field("status", want.status, o_out_data.status);
                    if (o_out_data.page_number !== want.page_number)
                        report_field("page_number", want.page_number, o_out_data.page_number);
                    if (o_out_data.frame_number !== want.frame_number)
                        report_field("frame_number", want.frame_number,
                                     o_out_data.frame_number);
                    if (o_out_data.frames_used !== want.frames_used)
                        report_field("frames_used", want.frames_used, o_out_data.frames_used);
                    if (o_out_data.last !== want.last)
                        report_field("last", want.last, o_out_data.last);
                    case (want.status)
                        ST_MAPPED: n_map++;
                        ST_FREED:  n_freed++;
                        ST_NOROOM: n_noroom++;
                        default:   n_busy_rej++;
                    endcase
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= WATCH_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, quiet);
            $display("** paged_frame_allocator_top: FAILED **");
            $finish;
        end
    end

    task automatic queue_req(input logic op, input int pid, input logic [SIZE_W-1:0] sz);
        t_in_item it;
        it.opcode       = op;
        it.process_id   = PID_W'(pid);
        it.request_size = sz;
        request_q.insert(request_q.size(), it);
        n_sent++;
    endtask

    task automatic queue_random_req();
        int r;
        logic [SIZE_W-1:0] mask;
        logic [SIZE_W-1:0] sz;
        r = $urandom_range(0, 99);
        mask = SIZE_W'((32'd1 << gen_shift) - 32'd1);
        if (r < 55) begin
            // mostly small page counts so allocations get through
            sz = SIZE_W'((32'($urandom_range(0, 6)) << gen_shift) | (32'($urandom) & 32'(mask)));
            queue_req(OP_ALLOC, $urandom_range(0, PROCS - 1), sz);
        end else if (r < 85) begin
            queue_req(OP_FREE, $urandom_range(0, PROCS - 1), SIZE_W'($urandom));
        end else if (r < 93) begin
            queue_req(OP_ALLOC, $urandom_range(0, 31), SIZE_W'($urandom));
        end else begin
            queue_req(1'($urandom_range(0, 1)), $urandom_range(PROCS, 31), SIZE_W'($urandom));
        end
    endtask

    task automatic wait_idle();
        do @(posedge i_clk); while (!(n_req == n_sent && grant_q.size() == 0));
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_shift(input logic [SHIFT_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        gen_shift  = v;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin
        logic [SHIFT_W-1:0] shifts[5];
        int ph;
        int k;
        shifts = '{4'd0, 4'd15, 4'd4, 4'd12, 4'd7};
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed, page_shift at its reset value
        queue_req(OP_ALLOC, 0, 16'd0);
        queue_req(OP_ALLOC, 0, 16'd0);          // already active
        queue_req(OP_ALLOC, 1, 16'd3071);
        queue_req(OP_ALLOC, 2, 16'hFFFF);       // huge request
        queue_req(OP_ALLOC, 26, 16'd0);         // out of range
        queue_req(OP_ALLOC, 31, 16'd0);
        queue_req(OP_FREE, 31, 16'hFFFF);
        queue_req(OP_FREE, 3, 16'd0);           // idle process
        queue_req(OP_FREE, 0, 16'd0);
        queue_req(OP_ALLOC, 3, 16'd1023);       // fills the hole at frame 0
        queue_req(OP_ALLOC, 4, 16'd5120);
        queue_req(OP_ALLOC, 5, 16'd22527);      // exactly full
        queue_req(OP_ALLOC, 6, 16'd0);          // no room
        queue_req(OP_FREE, 1, 16'd0);
        queue_req(OP_ALLOC, 6, 16'd2047);
        queue_req(OP_FREE, 3, 16'd0);
        queue_req(OP_FREE, 4, 16'd0);
        queue_req(OP_FREE, 5, 16'd0);
        queue_req(OP_FREE, 6, 16'd0);
        queue_req(OP_ALLOC, 25, 16'd32767);     // all frames to one process
        queue_req(OP_FREE, 25, 16'd0);
        queue_req(OP_ALLOC, 7, 16'd32768);      // one page over
        wait_idle();

        for (ph = 0; ph < 5; ph++) begin
            write_shift(shifts[ph]);
            if (ph == 4) idle_en = 1'b0;
            for (k = 0; k < PHASE_ITEMS; k++) queue_random_req();
            if (ph == 1) begin
                @(posedge i_clk);
                long_hold_req = 1'b1;
            end
            wait_idle();
        end

        if (grant_q.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, grant_q.size());
            fail_cnt++;
        end
        $display("Ran %0d requests over page_shift 10, 0, 15, 4, 12, 7", n_req);
        $display("Results: %0d pages mapped, %0d frees, %0d no-room, %0d already-active",
                 n_map, n_freed, n_noroom, n_busy_rej);
        if (fail_cnt == 0) begin
            $display("** paged_frame_allocator_top: PASSED **");
        end else begin
            $display("** paged_frame_allocator_top: FAILED **");
        end
        $finish;
    end

endmodule
